// ----- design/stb_pkg.sv -----
// Shared types, command codes and constants for the soft timer bank.
`timescale 1ns / 1ps

package stb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int CMD_W          = 4;
  localparam int ID_W           = 8;
  localparam int COUNT_W        = 32;
  localparam int GRANT_W        = 4;

  localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] FF_COUNT  = COUNT_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 4'd0,
    CMD_REQUEST      = 4'd1,
    CMD_RESERVE      = 4'd2,
    CMD_RELEASE      = 4'd3,
    CMD_START        = 4'd4,
    CMD_RESTART      = 4'd5,
    CMD_FREEZE       = 4'd6,
    CMD_RESUME       = 4'd7,
    CMD_FAST_FORWARD = 4'd8,
    CMD_QUERY        = 4'd9
  } cmd_t;

  // One timer record as it sits in the state memory.
  typedef struct packed {
    logic               run;
    logic               tmo;
    logic               auto_rl;
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] reload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    cmd_t               cmd;
    logic               is_alloc;
    logic [COUNT_W-1:0] start_count;
    logic               auto_reload;
  } alu_op_t;

  typedef struct packed {
    logic   status;
    entry_t entry;
  } alu_res_t;

endpackage

// ----- design/stb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/stb_entry_alu.sv -----
// Read-modify-write update of one timer record for tick and per-timer commands.
`timescale 1ns / 1ps

module stb_entry_alu (
  input  stb_pkg::alu_op_t  op,
  input  stb_pkg::entry_t   cur,
  output stb_pkg::alu_res_t res
);

  logic [stb_pkg::COUNT_W-1:0] rem_dec;
  logic [stb_pkg::COUNT_W-1:0] ld_cnt;
  logic                        ld_aut;

  assign rem_dec = cur.remaining - stb_pkg::COUNT_W'(1);

  // Start takes count and mode from the command, restart from the record.
  always_comb begin
    if (op.cmd == stb_pkg::CMD_START) begin
      ld_cnt = op.start_count;
      ld_aut = op.auto_reload;
    end else begin
      ld_cnt = cur.reload;
      ld_aut = cur.auto_rl;
    end
    if (ld_cnt < stb_pkg::MIN_COUNT) begin
      ld_cnt = stb_pkg::MIN_COUNT;
    end
  end

  always_comb begin
    res.status = 1'b0;
    res.entry  = cur;
    case (op.cmd)
      stb_pkg::CMD_TICK: begin
        if (cur.run && (cur.remaining != '0)) begin
          res.entry.remaining = rem_dec;
          if (rem_dec == '0) begin
            res.entry.tmo = 1'b1;
            if (cur.auto_rl) begin
              res.entry.remaining = cur.reload;
            end else begin
              res.entry.run = 1'b0;
            end
          end
        end
      end
      stb_pkg::CMD_RELEASE: begin
        // The timeout flag survives a release.
        res.entry.run       = 1'b0;
        res.entry.auto_rl   = 1'b0;
        res.entry.remaining = '0;
        res.entry.reload    = '0;
      end
      stb_pkg::CMD_START, stb_pkg::CMD_RESTART: begin
        if (op.is_alloc) begin
          res.entry.remaining = ld_cnt;
          res.entry.reload    = ld_cnt;
          res.entry.auto_rl   = ld_aut;
          res.entry.tmo       = 1'b0;
          res.entry.run       = 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      stb_pkg::CMD_FREEZE: begin
        res.entry.run = 1'b0;
      end
      stb_pkg::CMD_RESUME: begin
        if (op.is_alloc || (!cur.auto_rl && cur.tmo)) begin
          res.entry.run = 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      stb_pkg::CMD_FAST_FORWARD: begin
        if (op.is_alloc || cur.run) begin
          res.entry.remaining = stb_pkg::FF_COUNT;
        end else begin
          res.status = 1'b1;
        end
      end
      stb_pkg::CMD_QUERY: begin
        if (cur.auto_rl) begin
          res.entry.tmo = 1'b0;
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
  end

endmodule

// ----- design/soft_timer_bank.sv -----
// Soft timer bank: one command per input beat, timer records kept in a RAM.
// A command on one timer passes S_READ, S_MOD and S_FIN before its result beat;
// reserve, out-of-range ids and unknown codes go straight to S_FIN; request scans in S_SCAN.
// A tick walks every record through the single RAM port pair in S_TICK.
// Throughput: one command at a time; the next beat is taken once its result is in the output register.
// Reset (rst, synchronous) clears the allocation bits and the per-record valid bits,
// so every timer reads as all zero at once; no clearing pass is needed.
`timescale 1ns / 1ps

module soft_timer_bank #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stb_pkg::CMD_W-1:0]     command,
  input  logic [stb_pkg::ID_W-1:0]      timer_id,
  input  logic [stb_pkg::COUNT_W-1:0]   start_count,
  input  logic                          auto_reload,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [stb_pkg::GRANT_W-1:0]   granted_id,
  output logic                          is_running,
  output logic                          timed_out,
  output logic [stb_pkg::COUNT_W-1:0]   time_to_go
);

  // Address width of the record RAM, and a walk counter that can also hold
  // NUM_TIMERS itself to mark the end of a tick sweep.
  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [stb_pkg::GRANT_W-1:0] GRANT_NONE = stb_pkg::GRANT_W'(NUM_TIMERS);
  localparam logic [stb_pkg::ID_W:0]      ID_LIMIT   = (stb_pkg::ID_W + 1)'(NUM_TIMERS);
  localparam logic [CW-1:0]               WALK_END   = CW'(NUM_TIMERS);
  localparam logic [AW-1:0]               LAST_IDX   = AW'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_READ,
    S_MOD,
    S_FIN
  } state_t;

  state_t state;

  // Captured command beat.
  logic [stb_pkg::CMD_W-1:0]   cmd_q;
  logic [stb_pkg::ID_W-1:0]    id_q;
  logic [stb_pkg::COUNT_W-1:0] cnt_q;
  logic                        aut_q;

  // Allocation bits live in flops since request searches them.
  logic [NUM_TIMERS-1:0] alloc;
  logic [AW-1:0]         scan;

  // Tick sweep: walk issues reads, the record read on the previous cycle is
  // written back while the next one is read, so the two never collide.
  logic [CW-1:0] walk;
  logic          rd_live;
  logic [AW-1:0] wb_idx;

  // Staged result, moved to the output register when the slot frees up.
  logic                        res_status;
  logic [stb_pkg::GRANT_W-1:0] res_grant;
  logic                        res_run;
  logic                        res_tmo;
  logic [stb_pkg::COUNT_W-1:0] res_cnt;

  // RAM ports and per-record valid bits; a record never written reads as zero.
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [stb_pkg::ENTRY_W-1:0]  rd_data;
  logic [NUM_TIMERS-1:0]        entry_ok;
  logic                         rd_ok;
  stb_pkg::entry_t              cur;

  stb_pkg::alu_op_t  alu_op;
  stb_pkg::alu_res_t alu_res;

  logic in_range;
  logic [AW-1:0] id_idx;

  // Decisions taken on the incoming beat while idle.
  logic   reserve_ok;
  state_t idle_state_next;

  assign in_ready = (state == S_IDLE);
  assign in_range = ({1'b0, timer_id} < ID_LIMIT);
  assign id_idx   = id_q[AW-1:0];

  // Reserve is settled right away from the allocation bits.
  assign reserve_ok = (command == stb_pkg::CMD_RESERVE) && in_range &&
                      !alloc[timer_id[AW-1:0]];

  always_comb begin
    case (command)
      stb_pkg::CMD_TICK: begin
        idle_state_next = S_TICK;
      end
      stb_pkg::CMD_REQUEST: begin
        idle_state_next = S_SCAN;
      end
      stb_pkg::CMD_RELEASE, stb_pkg::CMD_START, stb_pkg::CMD_RESTART,
      stb_pkg::CMD_FREEZE, stb_pkg::CMD_RESUME, stb_pkg::CMD_FAST_FORWARD,
      stb_pkg::CMD_QUERY: begin
        idle_state_next = in_range ? S_READ : S_FIN;
      end
      default: begin
        idle_state_next = S_FIN;
      end
    endcase
  end

  assign cur = rd_ok ? stb_pkg::entry_t'(rd_data) : '0;

  always_comb begin
    alu_op.cmd         = (state == S_TICK) ? stb_pkg::CMD_TICK : stb_pkg::cmd_t'(cmd_q);
    alu_op.is_alloc    = alloc[id_idx];
    alu_op.start_count = cnt_q;
    alu_op.auto_reload = aut_q;
  end

  stb_entry_alu u_alu (
    .op  (alu_op),
    .cur (cur),
    .res (alu_res)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = id_idx;
    wr_en   = 1'b0;
    wr_addr = id_idx;
    case (state)
      S_READ: begin
        rd_en = 1'b1;
      end
      S_MOD: begin
        wr_en = 1'b1;
      end
      S_TICK: begin
        rd_en   = (walk != WALK_END);
        rd_addr = walk[AW-1:0];
        wr_en   = rd_live;
        wr_addr = wb_idx;
      end
      default: begin
      end
    endcase
  end

  stb_ram #(
    .WIDTH (stb_pkg::ENTRY_W),
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (alu_res.entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
      rd_ok    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_ok[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= entry_ok[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      alloc     <= '0;
      walk      <= '0;
      rd_live   <= 1'b0;
    end else begin
      // In S_FIN the output register is reloaded below instead.
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= command;
            id_q       <= timer_id;
            cnt_q      <= start_count;
            aut_q      <= auto_reload;
            res_status <= !reserve_ok;
            res_grant  <= reserve_ok ? stb_pkg::GRANT_W'(timer_id) : GRANT_NONE;
            res_run    <= 1'b0;
            res_tmo    <= 1'b0;
            res_cnt    <= '0;
            state      <= idle_state_next;
            case (command)
              stb_pkg::CMD_TICK: begin
                walk    <= '0;
                rd_live <= 1'b0;
              end
              stb_pkg::CMD_REQUEST: begin
                scan <= '0;
              end
              stb_pkg::CMD_RESERVE: begin
                if (reserve_ok) begin
                  alloc[timer_id[AW-1:0]] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // Lowest free timer wins; one allocation bit is looked at per cycle.
          if (!alloc[scan]) begin
            alloc[scan] <= 1'b1;
            res_status  <= 1'b0;
            res_grant   <= stb_pkg::GRANT_W'(scan);
            state       <= S_FIN;
          end else if (scan == LAST_IDX) begin
            state <= S_FIN;
          end else begin
            scan <= scan + AW'(1);
          end
        end
        S_TICK: begin
          if (walk != WALK_END) begin
            walk <= walk + CW'(1);
          end
          rd_live <= (walk != WALK_END);
          wb_idx  <= walk[AW-1:0];
          if ((walk == WALK_END) && !rd_live) begin
            res_status <= 1'b0;
            state      <= S_FIN;
          end
        end
        S_READ: begin
          state <= S_MOD;
        end
        S_MOD: begin
          res_status <= alu_res.status;
          if (cmd_q == stb_pkg::CMD_RELEASE) begin
            alloc[id_idx] <= 1'b0;
            res_grant     <= stb_pkg::GRANT_W'(id_q);
          end
          if (cmd_q == stb_pkg::CMD_QUERY) begin
            res_run <= cur.run;
            res_tmo <= cur.tmo;
            res_cnt <= cur.remaining;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            granted_id <= res_grant;
            is_running <= res_run;
            timed_out  <= res_tmo;
            time_to_go <= res_cnt;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The tick sweep must never read and write the same record in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("record RAM read and write hit the same entry");

  // A taken beat always starts work, so the input side closes right after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after a beat was taken");

  // At most one timer is allocated per cycle.
  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    $countones(alloc) <= $past($countones(alloc)) + 1)
    else $error("more than one timer allocated in one cycle");

  // The sweep counter stops at the end marker.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> (walk <= WALK_END))
    else $error("tick sweep ran past the last timer");
`endif

endmodule
